// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted insert table.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SUT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define SUT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the cycle after.
`define SUT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/sut_pkg.sv
// Types and constants for the sorted unique insert table.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package sut_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic rot;
    } cell_cmd_t;

endpackage

// File: rtl/sut_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on sut_pkg for field widths.
`timescale 1ns / 1ps

interface sut_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [sut_pkg::VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sut_res_if;
    logic                         valid;
    logic                         ready;
    logic [sut_pkg::VALUE_W-1:0]  value_res;
    logic [sut_pkg::STATUS_W-1:0] status;
    logic                         last;

    modport source (output valid, output value_res, output status, output last,
                    input ready);
    modport sink   (input valid, input value_res, input status, input last,
                    output ready);
endinterface

// File: rtl/sut_cell.sv
// One slot of the sorted chain: holds an entry, compares it to the key,
// and shifts from its left neighbor on insert or from its right on dump.
`timescale 1ns / 1ps

module sut_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  sut_pkg::cell_cmd_t    cmd,
    input  logic                  occ,
    input  logic                  tail,
    input  logic [DATA_WIDTH-1:0] cmp_key,
    input  logic [DATA_WIDTH-1:0] ins_key,
    input  logic [DATA_WIDTH-1:0] left_entry,
    input  logic                  left_ge,
    input  logic [DATA_WIDTH-1:0] right_entry,
    input  logic [DATA_WIDTH-1:0] head_entry,
    output logic [DATA_WIDTH-1:0] entry,
    output logic                  ge,
    output logic                  eq
);

    logic [DATA_WIDTH-1:0] entry_reg, entry_next;
    logic                  ge_reg, ge_next;
    logic                  eq_reg, eq_next;

    always_comb
    begin
        entry_next = entry_reg;
        ge_next    = ge_reg;
        eq_next    = eq_reg;
        if (cmd.cmp)
        begin
            // free slots count as greater, so the insert point is the first ge
            ge_next = !occ || ($signed(entry_reg) >= $signed(cmp_key));
            eq_next = occ && (entry_reg == cmp_key);
        end
        if (cmd.ins && ge_reg)
        begin
            entry_next = left_ge ? left_entry : ins_key;
        end
        else if (cmd.rot && occ)
        begin
            entry_next = tail ? head_entry : right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        ge_reg    <= ge_next;
        eq_reg    <= eq_next;
    end

    assign entry = entry_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule

// File: rtl/sorted_unique_insert_table.sv
// Sorted unique insert table: a chain of DEPTH cells holding signed values
// in ascending order without duplicates.
//
// Channels: req (req_type, value) in, res (value_res, status, last) out,
// both valid/ready; a transfer happens when valid and ready are high.
// An insert passes through the transfer cycle, where every cell compares
// its entry with the value in parallel, and the response state, which merges
// the per-cell flags into inserted/duplicate/full and shifts the upper cells
// right by one when inserted; its single status result is registered as it leaves.
// A dump follows the transfer cycle with one element per cycle while the
// output is free; for each, the occupied cells rotate left, cell 0 feeding the
// output register, so the contents are back in place when the last element
// leaves; an empty table gives one empty status from the response state. One item
// is in flight at a time; req.ready is high only while idle. A stalled
// receiver holds the output register and freezes the insert or the
// rotation until the result is taken.
// Reset clears the count, the control state and the output valid; the
// cell contents are not cleared and are never read beyond the count.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sorted_unique_insert_table #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sut_req_if.sink   req,
    sut_res_if.source res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RESP = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               remain_reg, remain_next;
    logic                           type_reg;
    logic [DATA_WIDTH-1:0]          key_reg;
    logic [DATA_WIDTH-1:0]          key_in;
    logic                           res_valid_reg, res_valid_next;
    logic [sut_pkg::VALUE_W-1:0]    res_value_reg, res_value_next;
    logic [sut_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                           res_last_reg, res_last_next;
    logic [sut_pkg::VALUE_W-1:0]    head_out;

    logic [DATA_WIDTH-1:0] entry [DEPTH];
    logic [DEPTH-1:0]      ge;
    logic [DEPTH-1:0]      eq;
    logic [DEPTH-1:0]      occ;
    logic [DEPTH-1:0]      tail;

    sut_pkg::cell_cmd_t cmd;
    logic               accept;
    logic               out_free;
    logic               dup;
    logic               full;

    assign accept   = req.valid && req.ready;
    assign out_free = !res_valid_reg || res.ready;
    assign dup      = |eq;
    assign full     = (count_reg == CNT_W'(DEPTH));

    generate
        if (DATA_WIDTH >= sut_pkg::VALUE_W)
        begin : g_wide
            assign key_in   = DATA_WIDTH'(req.value);
            assign head_out = entry[0][sut_pkg::VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign key_in   = req.value[DATA_WIDTH-1:0];
            assign head_out = sut_pkg::VALUE_W'($signed(entry[0]));
        end
    endgenerate

    assign cmd.cmp = accept;
    assign cmd.ins = (state_reg == S_RESP) && out_free && (type_reg == sut_pkg::REQ_INSERT)
                     && !dup && !full;
    assign cmd.rot = (state_reg == S_DUMP) && out_free;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_e;
            logic                  left_g;
            logic [DATA_WIDTH-1:0] right_e;

            assign occ[gi]  = (CNT_W'(gi) < count_reg);
            assign tail[gi] = (CNT_W'(gi + 1) == count_reg);

            if (gi == 0)
            begin : g_first
                assign left_e = key_reg;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = entry[gi-1];
                assign left_g = ge[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign right_e = entry[0];
            end
            else
            begin : g_inner
                assign right_e = entry[gi+1];
            end

            sut_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occ         (occ[gi]),
                .tail        (tail[gi]),
                .cmp_key     (key_in),
                .ins_key     (key_reg),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .head_entry  (entry[0]),
                .entry       (entry[gi]),
                .ge          (ge[gi]),
                .eq          (eq[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    remain_next = count_reg;
                    if ((req.req_type == sut_pkg::REQ_DUMP) && (count_reg != '0))
                    begin
                        state_next = S_DUMP;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_value_next = '0;
                    res_last_next  = 1'b1;
                    priority if (type_reg == sut_pkg::REQ_DUMP)
                    begin
                        res_status_next = sut_pkg::ST_EMPTY;
                    end
                    else if (dup)
                    begin
                        res_status_next = sut_pkg::ST_DUPLICATE;
                    end
                    else if (full)
                    begin
                        res_status_next = sut_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_status_next = sut_pkg::ST_INSERTED;
                        count_next      = count_reg + CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_value_next  = head_out;
                    res_status_next = sut_pkg::ST_ELEMENT;
                    res_last_next   = (remain_reg == CNT_W'(1));
                    remain_next     = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req.req_type;
            key_reg  <= key_in;
        end
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.value_res = res_value_reg;
    assign res.status    = res_status_reg;
    assign res.last      = res_last_reg;

    `SUT_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `SUT_ASSERT_NXT(a_insert_grows, cmd.ins, count_reg == $past(count_reg) + CNT_W'(1))
    `SUT_ASSERT_IMP(a_dump_nonempty, state_reg == S_DUMP, count_reg != '0)
    `SUT_ASSERT_IMP(a_ins_no_dup, cmd.ins, !dup && (count_reg < CNT_W'(DEPTH)))
    `SUT_ASSERT_NXT(a_dump_last, cmd.rot && (remain_reg == CNT_W'(1)),
                    res.last && (state_reg == S_IDLE))

endmodule

// File: bench/sorted_unique_insert_table_tb.sv
// Self-checking testbench for sorted_unique_insert_table: inserts and dumps with a
// sorted-set predictor, result checks and random stalls on both channels.
// Depends on sut_pkg, sut_if.sv and the RTL of sorted_unique_insert_table.
`timescale 1ns / 1ps

module sorted_unique_insert_table_tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [sut_pkg::VALUE_W-1:0]  value_res;
        logic [sut_pkg::STATUS_W-1:0] status;
        logic                         last;
    } table_result_t;

    logic clk;
    logic rst_n;

    sut_req_if req_ch ();
    sut_res_if res_ch ();

    sorted_unique_insert_table #(
        .DEPTH     (TABLE_DEPTH),
        .DATA_WIDTH(sut_pkg::VALUE_W)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .res  (res_ch)
    );

    logic [sut_pkg::VALUE_W-1:0] stored_values[$];
    table_result_t               expected_results[$];
    int                          mismatch_count;
    int                          cycle_count;
    int                          send_idle_pct;
    int                          recv_idle_pct;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] sorted_unique_insert_table_tb mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic push_result(input logic [sut_pkg::VALUE_W-1:0] v,
                               input logic [sut_pkg::STATUS_W-1:0] st,
                               input logic lst);
        table_result_t r;
        r.value_res = v;
        r.status    = st;
        r.last      = lst;
        expected_results.push_back(r);
    endtask

    // Sorted-set behavior: signed order, duplicates dropped, bounded size.
    task automatic predict_table_response(input logic kind,
                                          input logic [sut_pkg::VALUE_W-1:0] v);
        int pos;
        int n;
        n = stored_values.size();
        if (kind == sut_pkg::REQ_DUMP)
        begin
            if (n == 0)
                push_result('0, sut_pkg::ST_EMPTY, 1'b1);
            for (int i = 0; i < n; i++)
                push_result(stored_values[i], sut_pkg::ST_ELEMENT, i == n - 1);
            return;
        end
        pos = n;
        for (int i = 0; i < n; i++)
        begin
            if (stored_values[i] == v)
            begin
                push_result('0, sut_pkg::ST_DUPLICATE, 1'b1);
                return;
            end
            if ($signed(stored_values[i]) > $signed(v))
            begin
                pos = i;
                break;
            end
        end
        if (n >= TABLE_DEPTH)
        begin
            push_result('0, sut_pkg::ST_FULL, 1'b1);
            return;
        end
        stored_values.insert(pos, v);
        push_result('0, sut_pkg::ST_INSERTED, 1'b1);
    endtask

    task automatic send_item(input logic kind, input logic [sut_pkg::VALUE_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.req_type = kind;
        req_ch.value    = v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_table_response(kind, v);
    endtask

    task automatic send_random_item();
        logic [sut_pkg::VALUE_W-1:0] v;
        int                          pick;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            send_item(sut_pkg::REQ_DUMP, $urandom);
            return;
        end
        pick = $urandom_range(99);
        if (pick < 40 || stored_values.size() == 0)
            v = $urandom;
        else if (pick < 75)
            v = $urandom_range(100) - 50;
        else
            v = stored_values[$urandom_range(stored_values.size() - 1)];
        send_item(sut_pkg::REQ_INSERT, v);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Empty dump, signed extremes, values around -1, duplicates, bit patterns.
    task automatic test_directed();
        send_item(sut_pkg::REQ_DUMP, 32'h0000_0000);
        send_item(sut_pkg::REQ_INSERT, 32'h0000_0000);
        send_item(sut_pkg::REQ_INSERT, 32'h0000_0000);
        send_item(sut_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        send_item(sut_pkg::REQ_INSERT, 32'hFFFF_FFFE);
        send_item(sut_pkg::REQ_INSERT, 32'h8000_0000);
        send_item(sut_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        send_item(sut_pkg::REQ_INSERT, 32'h0000_0001);
        send_item(sut_pkg::REQ_DUMP, 32'hFFFF_FFFF);
        send_item(sut_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        send_item(sut_pkg::REQ_INSERT, 32'h8000_0000);
        send_item(sut_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        send_item(sut_pkg::REQ_INSERT, 32'h5555_5555);
        send_item(sut_pkg::REQ_INSERT, 32'hAAAA_AAAA);
        send_item(sut_pkg::REQ_INSERT, 32'hFFFF_FFFD);
        send_item(sut_pkg::REQ_INSERT, 32'h8000_0001);
        send_item(sut_pkg::REQ_DUMP, 32'h5555_5555);
    endtask

    task automatic test_random_mix();
        repeat (50) send_random_item();
    endtask

    // Fill to capacity, then full and duplicate answers and full-size dumps.
    task automatic test_full_table();
        while (stored_values.size() < TABLE_DEPTH)
            send_item(sut_pkg::REQ_INSERT, $urandom);
        send_item(sut_pkg::REQ_DUMP, $urandom);
        send_item(sut_pkg::REQ_INSERT, 32'h8000_0000);
        send_item(sut_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        send_item(sut_pkg::REQ_INSERT, stored_values[TABLE_DEPTH / 2]);
        send_item(sut_pkg::REQ_INSERT, stored_values[0] - 1);
        send_item(sut_pkg::REQ_INSERT, stored_values[TABLE_DEPTH - 1] + 1);
        repeat (15) send_random_item();
        send_item(sut_pkg::REQ_DUMP, $urandom);
    endtask

    always @(negedge clk)
    begin
        res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        table_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result with none expected: status %0d",
                                          res_ch.status));
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res_ch.status, want.status));
                if (res_ch.value_res !== want.value_res)
                    report_mismatch($sformatf("value_res %0d, expected %0d",
                                              $signed(res_ch.value_res),
                                              $signed(want.value_res)));
                if (res_ch.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              res_ch.last, want.last));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_unique_insert_table_tb: done, errors");
        $finish;
    end

    initial
    begin
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = sut_pkg::REQ_INSERT;
        req_ch.value    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 79;
        test_directed();

        send_idle_pct = 79;
        recv_idle_pct = 7;
        test_random_mix();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_table();

        wait_drained();
        if (mismatch_count == 0)
            $display("sorted_unique_insert_table_tb: done, clean");
        else
            $display("sorted_unique_insert_table_tb: done, errors");
        $finish;
    end

endmodule
